// ----- rtl/afrp_pkg.sv -----
// Package for the API frame receive parser: parser phases, result and config types,
// frame constants and code values. Used by every file in rtl/.
// No dependencies.
package afrp_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_LEN_HI  = 4'd1,
    PH_LEN_LO  = 4'd2,
    PH_TYPE    = 4'd3,
    PH_ADDR    = 4'd4,
    PH_SKIP    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_OTHER   = 4'd7,
    PH_CHECK   = 4'd8
  } phase_t;

  // Result kind
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Frame end status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SUM   = 2'd1;
  localparam logic [1:0] ST_OTHER     = 2'd2;
  localparam logic [1:0] ST_TOO_SHORT = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_TYPE  = 2'd2;

  // Configuration reset values
  localparam logic [7:0] START_RST   = 8'h7E;
  localparam logic [7:0] ESCAPE_RST  = 8'h7D;
  localparam logic [7:0] RX_TYPE_RST = 8'h90;

  // Frame layout constants
  localparam logic [7:0]  ESC_XOR      = 8'h20;
  localparam logic [15:0] HEADER_BYTES = 16'd12;
  localparam logic [15:0] ADDR_BYTES   = 16'd8;
  localparam logic [15:0] SKIP_BYTES   = 16'd3;

  typedef struct packed {
    logic [7:0] start_delim;
    logic [7:0] escape_mark;
    logic [7:0] rx_type;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_status;
    logic [63:0] sender_address;
    logic [15:0] payload_length;
    logic        last;
  } res_t;

endpackage

// ----- rtl/afrp_core.sv -----
// Frame parser state: unescaping, length/type/address decode, checksum and
// the result word each accepted byte produces. Depends on afrp_pkg.
module afrp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_fire,
  input  logic [7:0]      rx_byte,
  input  afrp_pkg::cfg_t  cfg,
  output logic            res_valid,
  output afrp_pkg::res_t  res
);

  afrp_pkg::phase_t phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        is_rx_r, is_rx_nxt;
  logic [63:0] addr_r, addr_nxt;

  logic [7:0]  ub;
  logic        esc_take;
  logic [15:0] left_dec;
  logic [15:0] len_minus_hdr;
  logic        len_long;

  // Unescaped byte and escape detection
  assign ub            = esc_r ? (rx_byte ^ afrp_pkg::ESC_XOR) : rx_byte;
  assign esc_take      = (phase_r != afrp_pkg::PH_HUNT) && !esc_r && (rx_byte == cfg.escape_mark);
  assign left_dec      = left_r - 16'd1;
  assign len_minus_hdr = len_r - afrp_pkg::HEADER_BYTES;
  assign len_long      = (len_r >= afrp_pkg::HEADER_BYTES);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    is_rx_nxt = is_rx_r;
    addr_nxt  = addr_r;
    if (byte_fire) begin
      if (phase_r == afrp_pkg::PH_HUNT) begin
        if (rx_byte == cfg.start_delim) begin
          phase_nxt = afrp_pkg::PH_LEN_HI;
          esc_nxt   = 1'b0;
          len_nxt   = '0;
          left_nxt  = '0;
          sum_nxt   = '0;
          is_rx_nxt = 1'b0;
          addr_nxt  = '0;
        end
      end else if (esc_take) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        case (phase_r)
          afrp_pkg::PH_LEN_HI: begin
            len_nxt   = {ub, 8'h00};
            phase_nxt = afrp_pkg::PH_LEN_LO;
          end
          afrp_pkg::PH_LEN_LO: begin
            len_nxt   = {len_r[15:8], ub};
            phase_nxt = afrp_pkg::PH_TYPE;
          end
          afrp_pkg::PH_TYPE: begin
            sum_nxt   = sum_r + ub;
            is_rx_nxt = (ub == cfg.rx_type);
            if (is_rx_nxt && len_long) begin
              left_nxt  = afrp_pkg::ADDR_BYTES;
              phase_nxt = afrp_pkg::PH_ADDR;
            end else begin
              left_nxt  = (len_r == 16'd0) ? 16'd0 : (len_r - 16'd1);
              phase_nxt = (left_nxt != 16'd0) ? afrp_pkg::PH_OTHER : afrp_pkg::PH_CHECK;
            end
          end
          afrp_pkg::PH_ADDR: begin
            sum_nxt  = sum_r + ub;
            addr_nxt = {addr_r[55:0], ub};
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              left_nxt  = afrp_pkg::SKIP_BYTES;
              phase_nxt = afrp_pkg::PH_SKIP;
            end
          end
          afrp_pkg::PH_SKIP: begin
            sum_nxt  = sum_r + ub;
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              left_nxt  = len_minus_hdr;
              phase_nxt = (len_minus_hdr != 16'd0) ? afrp_pkg::PH_PAYLOAD
                                                   : afrp_pkg::PH_CHECK;
            end
          end
          afrp_pkg::PH_PAYLOAD, afrp_pkg::PH_OTHER: begin
            sum_nxt  = sum_r + ub;
            left_nxt = left_dec;
            if (left_dec == 16'd0) phase_nxt = afrp_pkg::PH_CHECK;
          end
          afrp_pkg::PH_CHECK: begin
            phase_nxt = afrp_pkg::PH_HUNT;
          end
          default: begin
            phase_nxt = afrp_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // Result word
  always_comb begin
    res_valid          = 1'b0;
    res.kind           = afrp_pkg::KIND_DATA;
    res.data_byte      = 8'h00;
    res.frame_status   = afrp_pkg::ST_OK;
    res.sender_address = addr_r;
    res.payload_length = (is_rx_r && len_long) ? len_minus_hdr : 16'd0;
    res.last           = 1'b0;
    if (byte_fire && !esc_take) begin
      case (phase_r)
        afrp_pkg::PH_PAYLOAD: begin
          res_valid     = 1'b1;
          res.data_byte = ub;
        end
        afrp_pkg::PH_CHECK: begin
          res_valid = 1'b1;
          res.kind  = afrp_pkg::KIND_END;
          res.last  = 1'b1;
          if (!is_rx_r)             res.frame_status = afrp_pkg::ST_OTHER;
          else if (!len_long)       res.frame_status = afrp_pkg::ST_TOO_SHORT;
          else if (~sum_r == ub)    res.frame_status = afrp_pkg::ST_OK;
          else                      res.frame_status = afrp_pkg::ST_BAD_SUM;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= afrp_pkg::PH_HUNT;
      esc_r   <= 1'b0;
      len_r   <= '0;
      left_r  <= '0;
      sum_r   <= '0;
      is_rx_r <= 1'b0;
      addr_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      is_rx_r <= is_rx_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

// ----- rtl/api_frame_receive_parser.sv -----
// Top level of the API frame receive parser: configuration registers,
// parser core and one-entry result register. Depends on afrp_pkg, afrp_core.
//
// Takes one raw received byte per cycle: every byte word is folded into the
// parser state in the cycle it is accepted, and any payload or frame end word
// it yields is registered in a single output register. in_ready is high
// whenever that register is empty or is being emptied by out_ready, so the
// block sustains one byte per clock and only stalls while a result waits.
// Config writes (cfg_wr_en, cfg_index, cfg_data) take effect at once and are
// meant to happen while no frame is in flight.
module api_frame_receive_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_kind,
  output logic [7:0]                         out_data_byte,
  output logic [1:0]                         out_frame_status,
  output logic [63:0]                        out_sender_address,
  output logic [15:0]                        out_payload_length,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [afrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);

  afrp_pkg::cfg_t cfg_r;
  afrp_pkg::res_t res;
  afrp_pkg::res_t res_r;
  logic           res_valid;
  logic           out_valid_r;
  logic           in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delim <= afrp_pkg::START_RST;
      cfg_r.escape_mark <= afrp_pkg::ESCAPE_RST;
      cfg_r.rx_type     <= afrp_pkg::RX_TYPE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        afrp_pkg::CFG_START:   cfg_r.start_delim <= cfg_data;
        afrp_pkg::CFG_ESCAPE:  cfg_r.escape_mark <= cfg_data;
        afrp_pkg::CFG_RX_TYPE: cfg_r.rx_type     <= cfg_data;
        default: ;
      endcase
    end
  end

  afrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_data_byte      = res_r.data_byte;
  assign out_frame_status   = res_r.frame_status;
  assign out_sender_address = res_r.sender_address;
  assign out_payload_length = res_r.payload_length;
  assign out_last           = res_r.last;

endmodule

// ----- rtl/afrp_checker.sv -----
// Port-level checks for api_frame_receive_parser, attached by bind.
// Depends on afrp_pkg.
module afrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_data_byte,
  input logic [1:0]  out_frame_status,
  input logic [15:0] out_payload_length,
  input logic        out_last
);

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_data_byte) && $stable(out_frame_status) && $stable(out_last))
    else $error("stalled result changed");

  // last marks frame end words and nothing else
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == afrp_pkg::KIND_END)))
    else $error("last and kind disagree");

  // Payload words carry ok status and a nonzero payload length
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == afrp_pkg::KIND_DATA) |->
      (out_frame_status == afrp_pkg::ST_OK) && (out_payload_length != 16'd0))
    else $error("payload word with bad status or zero length");

endmodule

bind api_frame_receive_parser afrp_checker u_afrp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_data_byte      (out_data_byte),
  .out_frame_status   (out_frame_status),
  .out_payload_length (out_payload_length),
  .out_last           (out_last)
);
